[hdl/dmrs_pkg.sv]
// shared types and constants for the display mode register sanitizer
package dmrs_pkg;

    localparam int DivSteps = 16;

    localparam logic [1:0] CFG_VRAM_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_XRES  = 2'd1;
    localparam logic [1:0] CFG_MAX_YRES  = 2'd2;

    localparam logic [31:0] VRAM_SIZE_RST = 32'd16777216;
    localparam logic [15:0] MAX_XRES_RST  = 16'd16000;
    localparam logic [15:0] MAX_YRES_RST  = 16'd12000;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic        en;
        logic [15:0] bpp;
        logic [15:0] xres;
        logic [15:0] vw;
        logic [15:0] yres;
        logic [15:0] xoff;
        logic [15:0] yoff;
        logic [17:0] ll;
        logic [17:0] xbytes;
    } item_t;

endpackage

[hdl/dmrs_front.sv]
// first stage: depth check, width rounding, size and offset clamps, line and offset bytes
module dmrs_front
    import dmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic        enable,
    input  logic [15:0] req_bpp,
    input  logic [15:0] req_xres,
    input  logic [15:0] req_virt_width,
    input  logic [15:0] req_yres,
    input  logic [15:0] req_x_offset,
    input  logic [15:0] req_y_offset,
    input  logic [15:0] max_xres,
    input  logic [15:0] max_yres,
    output logic        out_valid,
    output item_t       out_item
);

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [5:0]  bits;
    logic [15:0] bpp_f;
    logic [15:0] xr;
    logic [15:0] vw;
    logic [15:0] yr;
    logic [21:0] ll_prod;
    logic [21:0] xb_prod;

    always_comb
    begin
        bits  = 6'd8;
        bpp_f = 16'd8;
        unique case (req_bpp)
            16'd4, 16'd8, 16'd16, 16'd24, 16'd32:
            begin
                bits  = req_bpp[5:0];
                bpp_f = req_bpp;
            end
            16'd15:
            begin
                bits  = 6'd16;
                bpp_f = req_bpp;
            end
            default:
            begin
                bits  = 6'd8;
                bpp_f = 16'd8;
            end
        endcase

        xr = {req_xres[15:3], 3'b000};
        if (xr == 16'd0)
            xr = 16'd8;
        if (xr > max_xres)
            xr = max_xres;
        vw = {req_virt_width[15:3], 3'b000};
        if (vw > max_xres)
            vw = max_xres;
        if (vw < xr)
            vw = xr;
        yr = req_yres;
        if (yr == 16'd0)
            yr = 16'd1;
        if (yr > max_yres)
            yr = max_yres;

        item_next.en = enable;
        if (enable)
        begin
            item_next.bpp  = bpp_f;
            item_next.xres = xr;
            item_next.vw   = vw;
            item_next.yres = yr;
            item_next.xoff = (req_x_offset > max_xres) ? max_xres : req_x_offset;
            item_next.yoff = (req_y_offset > max_yres) ? max_yres : req_y_offset;
        end
        else
        begin
            item_next.bpp  = req_bpp;
            item_next.xres = req_xres;
            item_next.vw   = req_virt_width;
            item_next.yres = req_yres;
            item_next.xoff = req_x_offset;
            item_next.yoff = req_y_offset;
        end
        ll_prod = item_next.vw * bits;
        xb_prod = item_next.xoff * bits;
        item_next.ll     = ll_prod[20:3];
        item_next.xbytes = xb_prod[20:3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hdl/dmrs_div.sv]
// pipelined restoring divider: lines that fit, one quotient bit per stage
module dmrs_div
    import dmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [31:0] vram_size,
    output logic        out_valid,
    output item_t       out_item,
    output logic [15:0] quot,
    output logic        sat
);

    logic        valid_reg [DivSteps];
    item_t       item_reg  [DivSteps];
    logic [17:0] rem_reg   [DivSteps];
    logic [15:0] q_reg     [DivSteps];
    logic        sat_reg   [DivSteps];

    logic [17:0] rem_in    [DivSteps];
    logic [15:0] q_in      [DivSteps];
    logic        sat_in    [DivSteps];
    item_t       item_in   [DivSteps];
    logic        valid_in  [DivSteps];
    logic [17:0] rem_next  [DivSteps];
    logic [15:0] q_next    [DivSteps];
    logic [18:0] trial     [DivSteps];

    always_comb
    begin
        // quotient saturates when it would not fit in 16 bits
        valid_in[0] = in_valid;
        item_in[0]  = in_item;
        sat_in[0]   = (in_item.ll == 18'd0) || ({2'b00, vram_size[31:16]} >= in_item.ll);
        rem_in[0]   = {2'b00, vram_size[31:16]};
        q_in[0]     = 16'd0;
        for (int k = 1; k < DivSteps; k++)
        begin
            valid_in[k] = valid_reg[k-1];
            item_in[k]  = item_reg[k-1];
            sat_in[k]   = sat_reg[k-1];
            rem_in[k]   = rem_reg[k-1];
            q_in[k]     = q_reg[k-1];
        end
        for (int k = 0; k < DivSteps; k++)
        begin
            trial[k]  = {rem_in[k], vram_size[DivSteps-1-k]};
            q_next[k] = q_in[k];
            if (trial[k] >= {1'b0, item_in[k].ll})
            begin
                rem_next[k] = 18'(trial[k] - {1'b0, item_in[k].ll});
                q_next[k][DivSteps-1-k] = 1'b1;
            end
            else
                rem_next[k] = trial[k][17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DivSteps; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < DivSteps; k++)
                valid_reg[k] <= valid_in[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DivSteps; k++)
            begin
                item_reg[k] <= item_in[k];
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                sat_reg[k]  <= sat_in[k];
            end
        end
    end

    assign out_valid = valid_reg[DivSteps-1];
    assign out_item  = item_reg[DivSteps-1];
    assign quot      = q_reg[DivSteps-1];
    assign sat       = sat_reg[DivSteps-1];

endmodule

[hdl/dmrs_back.sv]
// height clamp, window products, overrun checks and output register
module dmrs_back
    import dmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [15:0] quot,
    input  logic        sat,
    input  logic [31:0] vram_size,
    output logic        out_valid,
    output logic        applied,
    output logic [15:0] fixed_bpp,
    output logic [15:0] fixed_xres,
    output logic [15:0] fixed_virt_width,
    output logic [15:0] fixed_yres,
    output logic [15:0] fixed_x_offset,
    output logic [15:0] fixed_y_offset,
    output logic [15:0] virt_height,
    output logic [17:0] line_bytes,
    output logic [29:0] start_word
);

    logic        mv_reg;
    item_t       mi_reg;
    logic [15:0] mvh_reg;
    logic [33:0] py_reg;
    logic [33:0] pr_reg;
    item_t       mi_next;
    logic [15:0] maxy;

    logic        ov_reg;
    logic        ap_reg;
    logic [15:0] bpp_reg, xr_reg, vw_reg, yr_reg, xo_reg, yo_reg, vh_reg;
    logic [17:0] ll_reg;
    logic [29:0] sw_reg;
    logic [35:0] sum_a;
    logic [35:0] sum_b;
    logic [34:0] offset;
    logic [15:0] xo_next;
    logic [15:0] yo_next;

    always_comb
    begin
        maxy    = sat ? SAT16 : quot;
        mi_next = in_item;
        if (in_item.en && (in_item.yres > maxy))
            mi_next.yres = maxy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            mv_reg <= in_valid;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mi_reg  <= mi_next;
            mvh_reg <= maxy;
            py_reg  <= mi_next.yoff * mi_next.ll;
            pr_reg  <= mi_next.yres * mi_next.ll;
        end
    end

    // pan is dropped vertically first, then horizontally, if the window overruns
    always_comb
    begin
        sum_a   = 36'(mi_reg.xbytes) + 36'(py_reg) + 36'(pr_reg);
        sum_b   = 36'(mi_reg.xbytes) + 36'(pr_reg);
        xo_next = mi_reg.xoff;
        yo_next = mi_reg.yoff;
        offset  = 35'(mi_reg.xbytes) + 35'(py_reg);
        if (mi_reg.en && (sum_a > 36'(vram_size)))
        begin
            yo_next = 16'd0;
            offset  = 35'(mi_reg.xbytes);
            if (sum_b > 36'(vram_size))
            begin
                xo_next = 16'd0;
                offset  = 35'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ap_reg  <= mi_reg.en;
            bpp_reg <= mi_reg.bpp;
            xr_reg  <= mi_reg.xres;
            vw_reg  <= mi_reg.vw;
            yr_reg  <= mi_reg.yres;
            xo_reg  <= xo_next;
            yo_reg  <= yo_next;
            vh_reg  <= mi_reg.en ? mvh_reg : 16'd0;
            ll_reg  <= mi_reg.en ? mi_reg.ll : 18'd0;
            sw_reg  <= mi_reg.en ? offset[31:2] : 30'd0;
        end
    end

    assign out_valid        = ov_reg;
    assign applied          = ap_reg;
    assign fixed_bpp        = bpp_reg;
    assign fixed_xres       = xr_reg;
    assign fixed_virt_width = vw_reg;
    assign fixed_yres       = yr_reg;
    assign fixed_x_offset   = xo_reg;
    assign fixed_y_offset   = yo_reg;
    assign virt_height      = vh_reg;
    assign line_bytes       = ll_reg;
    assign start_word       = sw_reg;

endmodule

[hdl/display_mode_register_sanitizer.sv]
// Display mode register sanitizer, top level.
// One requested display mode enters as a beat on the input channel
// (in_valid / in_stall) and one corrected mode leaves as a beat on the
// output channel (out_valid / out_stall). A beat moves at a clock edge
// with valid high and stall low.
// The pipeline has one stage of depth and width fixup, sixteen
// divider stages (one quotient bit each) for the lines that fit in video
// memory, one multiply stage and one compare stage that is the output
// register. A new request can enter every cycle unless the pipeline is held.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is dropped.
// Reset empties the pipeline and loads vram_size = 16777216, max_xres
// = 16000 and max_yres = 12000. Registers are written through cfg_we /
// cfg_index / cfg_data (0 vram_size, 1 max_xres, 2 max_yres); the user
// must do so only while no request is in flight; the block does not enforce it.
module display_mode_register_sanitizer
    import dmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        enable,
    input  logic [15:0] req_bpp,
    input  logic [15:0] req_xres,
    input  logic [15:0] req_virt_width,
    input  logic [15:0] req_yres,
    input  logic [15:0] req_x_offset,
    input  logic [15:0] req_y_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        applied,
    output logic [15:0] fixed_bpp,
    output logic [15:0] fixed_xres,
    output logic [15:0] fixed_virt_width,
    output logic [15:0] fixed_yres,
    output logic [15:0] fixed_x_offset,
    output logic [15:0] fixed_y_offset,
    output logic [15:0] virt_height,
    output logic [17:0] line_bytes,
    output logic [29:0] start_word
);

    logic [31:0] vram_size_reg;
    logic [15:0] max_xres_reg;
    logic [15:0] max_yres_reg;
    logic        adv;
    logic        f_valid;
    item_t       f_item;
    logic        d_valid;
    item_t       d_item;
    logic [15:0] d_quot;
    logic        d_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_size_reg <= VRAM_SIZE_RST;
            max_xres_reg  <= MAX_XRES_RST;
            max_yres_reg  <= MAX_YRES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VRAM_SIZE: vram_size_reg <= cfg_data;
                CFG_MAX_XRES:  max_xres_reg  <= cfg_data[15:0];
                CFG_MAX_YRES:  max_yres_reg  <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    dmrs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .enable         (enable),
        .req_bpp        (req_bpp),
        .req_xres       (req_xres),
        .req_virt_width (req_virt_width),
        .req_yres       (req_yres),
        .req_x_offset   (req_x_offset),
        .req_y_offset   (req_y_offset),
        .max_xres       (max_xres_reg),
        .max_yres       (max_yres_reg),
        .out_valid      (f_valid),
        .out_item       (f_item)
    );

    dmrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .vram_size (vram_size_reg),
        .out_valid (d_valid),
        .out_item  (d_item),
        .quot      (d_quot),
        .sat       (d_sat)
    );

    dmrs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (d_valid),
        .in_item          (d_item),
        .quot             (d_quot),
        .sat              (d_sat),
        .vram_size        (vram_size_reg),
        .out_valid        (out_valid),
        .applied          (applied),
        .fixed_bpp        (fixed_bpp),
        .fixed_xres       (fixed_xres),
        .fixed_virt_width (fixed_virt_width),
        .fixed_yres       (fixed_yres),
        .fixed_x_offset   (fixed_x_offset),
        .fixed_y_offset   (fixed_y_offset),
        .virt_height      (virt_height),
        .line_bytes       (line_bytes),
        .start_word       (start_word)
    );

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !applied |->
            line_bytes == 18'd0 && virt_height == 16'd0 && start_word == 30'd0)
        else $error("disabled mode carries nonzero derived fields");

    a_vw_covers_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && applied |-> fixed_virt_width >= fixed_xres)
        else $error("virtual width below visible width");

    a_height_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && applied |-> fixed_yres <= virt_height)
        else $error("height exceeds lines that fit");

    a_pan_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && applied && fixed_y_offset != 16'd0 |->
            fixed_y_offset <= max_yres_reg)
        else $error("y offset above limit");

endmodule

[sim/display_mode_register_sanitizer_tb.sv]
// testbench for the display mode register sanitizer: random and directed modes against a predictor
`timescale 1ns / 100ps

module display_mode_register_sanitizer_tb;
    import dmrs_pkg::*;

    typedef struct {
        logic        en;
        logic [15:0] bpp;
        logic [15:0] xres;
        logic [15:0] vw;
        logic [15:0] yres;
        logic [15:0] xoff;
        logic [15:0] yoff;
    } mode_req_t;

    typedef struct {
        logic        applied;
        logic [15:0] bpp;
        logic [15:0] xres;
        logic [15:0] vw;
        logic [15:0] yres;
        logic [15:0] xoff;
        logic [15:0] yoff;
        logic [15:0] vheight;
        logic [17:0] lbytes;
        logic [29:0] sword;
    } safe_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_VRAM_SIZE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        enable = 1'b0;
    logic [15:0] req_bpp = '0;
    logic [15:0] req_xres = '0;
    logic [15:0] req_virt_width = '0;
    logic [15:0] req_yres = '0;
    logic [15:0] req_x_offset = '0;
    logic [15:0] req_y_offset = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        applied;
    logic [15:0] fixed_bpp;
    logic [15:0] fixed_xres;
    logic [15:0] fixed_virt_width;
    logic [15:0] fixed_yres;
    logic [15:0] fixed_x_offset;
    logic [15:0] fixed_y_offset;
    logic [15:0] virt_height;
    logic [17:0] line_bytes;
    logic [29:0] start_word;

    // local copy of the block's registers
    logic [31:0] vram_bytes = VRAM_SIZE_RST;
    logic [15:0] xres_limit = MAX_XRES_RST;
    logic [15:0] yres_limit = MAX_YRES_RST;

    mode_req_t  pending_reqs[$];
    safe_mode_t expected_modes[$];
    mode_req_t  shown_req;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_left = 0;
    int         fail_count = 0;

    display_mode_register_sanitizer i_dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic safe_mode_t sanitize_mode(mode_req_t r);
        safe_mode_t m;
        logic [15:0] bpp;
        longint unsigned bits, xres, vw, yres, xoff, yoff, ll, maxy, xbytes, ofs, vram;
        m = '{default: '0};
        if (!r.en)
        begin
            m.bpp = r.bpp; m.xres = r.xres; m.vw = r.vw; m.yres = r.yres;
            m.xoff = r.xoff; m.yoff = r.yoff;
            return m;
        end
        bpp = r.bpp;
        case (r.bpp)
            16'd4, 16'd8, 16'd16, 16'd24, 16'd32: bits = r.bpp;
            16'd15: bits = 16;
            default:
            begin
                bpp = 16'd8;
                bits = 8;
            end
        endcase
        xres = r.xres & 16'hFFF8;
        if (xres == 0) xres = 8;
        if (xres > xres_limit) xres = xres_limit;
        vw = r.vw & 16'hFFF8;
        if (vw > xres_limit) vw = xres_limit;
        if (vw < xres) vw = xres;
        vram = vram_bytes;
        ll = vw * bits / 8;
        maxy = (ll == 0) ? 64'hFFFF_FFFF : vram / ll;
        yres = r.yres;
        if (yres == 0) yres = 1;
        if (yres > yres_limit) yres = yres_limit;
        if (yres > maxy) yres = maxy;
        xoff = (r.xoff > xres_limit) ? xres_limit : r.xoff;
        yoff = (r.yoff > yres_limit) ? yres_limit : r.yoff;
        xbytes = xoff * bits / 8;
        ofs = xbytes + yoff * ll;
        // window overruns memory: drop the vertical pan, then the horizontal one
        if (ofs + yres * ll > vram)
        begin
            yoff = 0;
            ofs = xbytes;
            if (ofs + yres * ll > vram)
            begin
                xoff = 0;
                ofs = 0;
            end
        end
        ofs = ofs / 4;
        m.applied = 1'b1;
        m.bpp = bpp;
        m.xres = xres[15:0];
        m.vw = vw[15:0];
        m.yres = yres[15:0];
        m.xoff = xoff[15:0];
        m.yoff = yoff[15:0];
        m.vheight = (maxy > 65535) ? SAT16 : maxy[15:0];
        m.lbytes = ll[17:0];
        m.sword = ofs[29:0];
        return m;
    endfunction

    task automatic check_field(string name, longint unsigned exp_val, longint unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_modes.push_back(sanitize_mode(shown_req));
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    shown_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    enable <= shown_req.en;
                    req_bpp <= shown_req.bpp;
                    req_xres <= shown_req.xres;
                    req_virt_width <= shown_req.vw;
                    req_yres <= shown_req.yres;
                    req_x_offset <= shown_req.xoff;
                    req_y_offset <= shown_req.yoff;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        safe_mode_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_modes.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_modes.pop_front();
                    check_field("applied", e.applied, applied);
                    check_field("fixed_bpp", e.bpp, fixed_bpp);
                    check_field("fixed_xres", e.xres, fixed_xres);
                    check_field("fixed_virt_width", e.vw, fixed_virt_width);
                    check_field("fixed_yres", e.yres, fixed_yres);
                    check_field("fixed_x_offset", e.xoff, fixed_x_offset);
                    check_field("fixed_y_offset", e.yoff, fixed_y_offset);
                    check_field("virt_height", e.vheight, virt_height);
                    check_field("line_bytes", e.lbytes, line_bytes);
                    check_field("start_word", e.sword, start_word);
                end
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VRAM_SIZE: vram_bytes = val;
            CFG_MAX_XRES:  xres_limit = val[15:0];
            default:       yres_limit = val[15:0];
        endcase
    endtask

    // sender pause: nothing queued, nothing shown, nothing outstanding
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_modes.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic add_req(logic en, logic [15:0] bpp, logic [15:0] xres, logic [15:0] vw,
                           logic [15:0] yres, logic [15:0] xoff, logic [15:0] yoff);
        pending_reqs.push_back('{en, bpp, xres, vw, yres, xoff, yoff});
    endtask

    function automatic logic [15:0] pick_dim(int unsigned lim);
        return ($urandom_range(1)) ? 16'($urandom_range(lim)) : 16'($urandom);
    endfunction

    function automatic mode_req_t random_req();
        mode_req_t r;
        logic [15:0] depths[6] = '{16'd4, 16'd8, 16'd15, 16'd16, 16'd24, 16'd32};
        r.en = ($urandom_range(9) != 0);
        r.bpp = ($urandom_range(3) != 0) ? depths[$urandom_range(5)] : 16'($urandom);
        r.xres = pick_dim(2048);
        r.vw = pick_dim(4096);
        r.yres = pick_dim(1600);
        r.xoff = pick_dim(1024);
        r.yoff = pick_dim(2048);
        return r;
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed modes at reset settings
        add_req(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_req(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_req(1'b1, 16'd4, 16'd640, 16'd640, 16'd480, 16'd0, 16'd0);
        add_req(1'b1, 16'd8, 16'd800, 16'd1024, 16'd600, 16'd16, 16'd10);
        add_req(1'b1, 16'd15, 16'd1024, 16'd1024, 16'd768, 16'd3, 16'd7);
        add_req(1'b1, 16'd16, 16'd1280, 16'd1280, 16'd1024, 16'd100, 16'd100);
        add_req(1'b1, 16'd24, 16'd1600, 16'd1600, 16'd1200, 16'd1, 16'd1);
        add_req(1'b1, 16'd32, 16'd1920, 16'd2048, 16'd1080, 16'd64, 16'd900);
        add_req(1'b1, 16'd0, 16'd640, 16'd640, 16'd480, 16'd0, 16'd0);
        add_req(1'b1, 16'hFFFF, 16'd640, 16'd640, 16'd480, 16'd0, 16'd0);
        add_req(1'b1, 16'd32, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_req(1'b1, 16'd8, 16'd7, 16'd3, 16'd1, 16'd0, 16'd0);
        add_req(1'b1, 16'd32, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_req(1'b1, 16'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_req(1'b1, 16'd32, 16'd4096, 16'd4096, 16'd1000, 16'd0, 16'd60000);
        add_req(1'b1, 16'd32, 16'd16000, 16'd16000, 16'd262, 16'd16000, 16'd5);
        add_req(1'b1, 16'd16, 16'd1024, 16'd512, 16'd768, 16'd8, 16'd8);
        add_req(1'b1, 16'd24, 16'd1023, 16'd1031, 16'd700, 16'd5, 16'd3);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_VRAM_SIZE, VRAM_SIZE_RST);
                    write_reg(CFG_MAX_XRES, 32'(MAX_XRES_RST));
                    write_reg(CFG_MAX_YRES, 32'(MAX_YRES_RST));
                end
                1:
                begin
                    write_reg(CFG_VRAM_SIZE, 32'd0);
                    write_reg(CFG_MAX_XRES, 32'd8);
                    write_reg(CFG_MAX_YRES, 32'd1);
                end
                2:
                begin
                    write_reg(CFG_VRAM_SIZE, 32'hFFFF_FFFF);
                    write_reg(CFG_MAX_XRES, 32'd65535);
                    write_reg(CFG_MAX_YRES, 32'd65535);
                end
                3:
                begin
                    write_reg(CFG_VRAM_SIZE, $urandom_range(32'h0100_0000, 4096));
                    write_reg(CFG_MAX_XRES, $urandom_range(4096, 8));
                    write_reg(CFG_MAX_YRES, $urandom_range(2048, 1));
                end
                4:
                begin
                    write_reg(CFG_VRAM_SIZE, 32'd2097152);
                    write_reg(CFG_MAX_XRES, 32'd1920);
                    write_reg(CFG_MAX_YRES, 32'd1200);
                end
                default:
                begin
                    write_reg(CFG_VRAM_SIZE, $urandom);
                    write_reg(CFG_MAX_XRES, $urandom_range(65535, 8));
                    write_reg(CFG_MAX_YRES, $urandom_range(65535, 1));
                end
            endcase
            if (p < 2)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 56;
            end
            else if (p < 4)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 230; k++)
                pending_reqs.push_back(random_req());
            // long receiver hold so the pipeline fills and backs up
            if (p == 4)
                hold_left <= 300;
            drain();
        end

        if (fail_count == 0)
            $display("display_mode_register_sanitizer_tb: PASS");
        else
            $display("display_mode_register_sanitizer_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("display_mode_register_sanitizer_tb: FAIL");
        $finish;
    end

endmodule
